/* rtl/core/trim_button_autorepeat_macros.svh */
// Assertion macros for the trim button block
`ifndef TRIM_BUTTON_AUTOREPEAT_MACROS_SVH
`define TRIM_BUTTON_AUTOREPEAT_MACROS_SVH

// same-cycle implication
`define TBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/tba_pkg.sv */
// Types, constants and helper functions shared by the trim button block
`timescale 1ns / 1ps

package tba_pkg;

	localparam int unsigned RANGE_W = 14;
	localparam int unsigned STEP_W  = 10;
	localparam int unsigned TRIM_W  = 16;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned BEEP_W  = 3;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [RANGE_W-1:0] RANGE_RESET = RANGE_W'(1000);
	localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(10);

	localparam logic [TIME_W-1:0] REPEAT_START_MS = TIME_W'(250);
	localparam logic [TIME_W-1:0] REPEAT_PAUSE_MS = TIME_W'(500);
	localparam logic [TIME_W-1:0] REPEAT_EVERY_MS = TIME_W'(50);

	// largest magnitude the trim can reach: range plus one overshooting step
	localparam int TRIM_LIMIT = (1 << RANGE_W) - 1 + (1 << STEP_W) - 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RANGE_LIM = 1'd0,
		CFG_TRIM_STEP = 1'd1
	} cfg_idx_t;

	typedef enum logic [BEEP_W-1:0] {
		BEEP_NONE   = 3'd0,
		BEEP_STEP   = 3'd1,
		BEEP_CENTRE = 3'd2,
		BEEP_MIN    = 3'd3,
		BEEP_MAX    = 3'd4
	} beep_t;

	typedef enum logic [5:0] {
		PH_IDLE         = 6'b000001,
		PH_DOWN_PRESSED = 6'b000010,
		PH_UP_PRESSED   = 6'b000100,
		PH_DOWN_HELD    = 6'b001000,
		PH_UP_HELD      = 6'b010000,
		PH_WAIT_RELEASE = 6'b100000
	} phase_t;

	typedef struct packed {
		logic              down_button;
		logic              up_button;
		logic [TIME_W-1:0] now_ms;
	} item_t;

	typedef struct packed {
		logic signed [TRIM_W-1:0] trim_value;
		logic [BEEP_W-1:0]        beep_kind;
	} result_t;

	typedef struct packed {
		logic [RANGE_W-1:0] range_lim;
		logic [STEP_W-1:0]  trim_step;
	} cfg_t;

	typedef struct packed {
		phase_t                   phase;
		logic [TIME_W-1:0]        time_mark;
		logic signed [TRIM_W-1:0] trim_level;
	} state_t;

	function automatic beep_t beep_class(input logic signed [TRIM_W-1:0] v,
			input logic [RANGE_W-1:0] range);
		logic signed [TRIM_W:0] v_x;
		logic signed [TRIM_W:0] r_x;
		v_x = {v[TRIM_W-1], v};
		r_x = signed'({{(TRIM_W + 1 - RANGE_W){1'b0}}, range});
		if (v_x == '0) begin
			return BEEP_CENTRE;
		end else if (v_x >= r_x) begin
			return BEEP_MAX;
		end else if (v_x <= -r_x) begin
			return BEEP_MIN;
		end else begin
			return BEEP_STEP;
		end
	endfunction

endpackage

/* rtl/core/tba_cfg_regs.sv */
// Configuration registers for trim range and trim step
`timescale 1ns / 1ps

module tba_cfg_regs
	import tba_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [RANGE_W-1:0]   wr_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_lim <= RANGE_RESET;
			cfg_q.trim_step <= STEP_RESET;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				CFG_RANGE_LIM: cfg_q.range_lim <= wr_data;
				CFG_TRIM_STEP: cfg_q.trim_step <= wr_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/core/tba_next_state.sv */
// Button phase machine, trim stepping and beep selection for one word
`timescale 1ns / 1ps

module tba_next_state
	import tba_pkg::*;
(
	input  item_t   item,
	input  cfg_t    cfg,
	input  state_t  cur,
	output state_t  nxt,
	output result_t res
);

	logic                     dn;
	logic                     up;
	logic signed [TRIM_W:0]   lvl_x;
	logic signed [TRIM_W:0]   rng_x;
	logic signed [TRIM_W:0]   stp_x;
	logic signed [TRIM_W:0]   lvl_dn_x;
	logic signed [TRIM_W:0]   lvl_up_x;
	logic signed [TRIM_W-1:0] lvl_dn;
	logic signed [TRIM_W-1:0] lvl_up;
	logic                     can_dn;
	logic                     can_up;
	logic                     to_start;
	logic                     to_every;
	logic                     is_down;
	logic                     held;
	beep_t                    beep;

	assign dn = item.down_button;
	assign up = item.up_button;

	assign lvl_x    = {cur.trim_level[TRIM_W-1], cur.trim_level};
	assign rng_x    = signed'({{(TRIM_W + 1 - RANGE_W){1'b0}}, cfg.range_lim});
	assign stp_x    = signed'({{(TRIM_W + 1 - STEP_W){1'b0}}, cfg.trim_step});
	assign lvl_dn_x = lvl_x - stp_x;
	assign lvl_up_x = lvl_x + stp_x;
	assign lvl_dn   = lvl_dn_x[TRIM_W-1:0];
	assign lvl_up   = lvl_up_x[TRIM_W-1:0];
	assign can_dn   = lvl_x > -rng_x;
	assign can_up   = lvl_x < rng_x;

	assign to_start = item.now_ms > (cur.time_mark + REPEAT_START_MS);
	assign to_every = item.now_ms > (cur.time_mark + REPEAT_EVERY_MS);
	assign is_down  = (cur.phase == PH_DOWN_HELD);
	assign held     = is_down ? dn : up;

	always_comb begin
		nxt  = cur;
		beep = BEEP_NONE;
		case (cur.phase)
			PH_IDLE: begin
				if (dn) begin
					nxt.phase     = PH_DOWN_PRESSED;
					nxt.time_mark = item.now_ms;
				end else if (up) begin
					nxt.phase     = PH_UP_PRESSED;
					nxt.time_mark = item.now_ms;
				end
			end
			PH_DOWN_PRESSED: begin
				if (!dn) begin
					if (can_dn) begin
						nxt.trim_level = lvl_dn;
					end
					beep      = beep_class(nxt.trim_level, cfg.range_lim);
					nxt.phase = PH_IDLE;
				end else if (up) begin
					nxt.trim_level = '0;
					beep           = BEEP_CENTRE;
					nxt.phase      = PH_WAIT_RELEASE;
				end else if (to_start) begin
					nxt.phase     = PH_DOWN_HELD;
					nxt.time_mark = item.now_ms;
				end
			end
			PH_UP_PRESSED: begin
				if (!up) begin
					if (can_up) begin
						nxt.trim_level = lvl_up;
					end
					beep      = beep_class(nxt.trim_level, cfg.range_lim);
					nxt.phase = PH_IDLE;
				end else if (dn) begin
					nxt.trim_level = '0;
					beep           = BEEP_CENTRE;
					nxt.phase      = PH_WAIT_RELEASE;
				end else if (to_start) begin
					nxt.phase     = PH_UP_HELD;
					nxt.time_mark = item.now_ms;
				end
			end
			PH_DOWN_HELD, PH_UP_HELD: begin
				if (!held) begin
					nxt.phase = PH_WAIT_RELEASE;
				end else if (to_every) begin
					if (is_down && can_dn) begin
						nxt.trim_level = lvl_dn;
						beep           = beep_class(lvl_dn, cfg.range_lim);
					end else if (!is_down && can_up) begin
						nxt.trim_level = lvl_up;
						beep           = beep_class(lvl_up, cfg.range_lim);
					end
					// pause longer when passing through center
					if (nxt.trim_level == '0) begin
						nxt.time_mark = item.now_ms + REPEAT_PAUSE_MS;
					end else begin
						nxt.time_mark = item.now_ms;
					end
				end
			end
			PH_WAIT_RELEASE: begin
				if (!dn && !up) begin
					nxt.phase = PH_IDLE;
				end
			end
			default: begin
				nxt.phase = PH_IDLE;
			end
		endcase
	end

	assign res.trim_value = nxt.trim_level;
	assign res.beep_kind  = beep;

endmodule

/* rtl/core/trim_button_autorepeat.sv */
// Top level of the two-button trim block with auto-repeat
// Two-button trim with auto-repeat. Each input word carries the down and up
// button levels and the millisecond time; each one yields exactly one result
// word with the trim value and a beep class. The block takes one word per
// clock cycle unless the result is stalled: the word is registered, the
// button phase machine and trim stepping resolve in combinational logic, and
// the result is registered. The input side stalls only when both the input
// register and the result register are full and the result is being
// stalled. Configuration writes are always ready.
`timescale 1ns / 1ps

`include "trim_button_autorepeat_macros.svh"

module trim_button_autorepeat
	import tba_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  item_t                item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [RANGE_W-1:0]   cfg_data
);

	cfg_t    cfg;
	logic    valid_s1;
	item_t   item_s1;
	logic    result_valid_q;
	result_t result_q;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	logic    advance;
	logic    take;

	assign cfg_ready = 1'b1;

	tba_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	tba_next_state u_next (
		.item (item_s1),
		.cfg  (cfg),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign take       = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase      <= PH_IDLE;
			state_q.time_mark  <= '0;
			state_q.trim_level <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`TBA_ASSERT_NOW(a_stall_only_full, clk, arst_n, item_stall, valid_s1 && result_valid_q, "input stalled while a register is free")
	`TBA_ASSERT_NEXT(a_s1_moves_on, clk, arst_n, valid_s1 && !result_valid_q, result_valid, "input word did not reach the result register")
	`TBA_ASSERT_NOW(a_centre_is_zero, clk, arst_n, result_valid && (result.beep_kind == BEEP_CENTRE), result.trim_value == '0, "center beep with nonzero trim")
	`TBA_ASSERT_NOW(a_trim_bounded, clk, arst_n, 1'b1, (state_q.trim_level <= TRIM_W'(TRIM_LIMIT)) && (state_q.trim_level >= -TRIM_W'(TRIM_LIMIT)), "trim beyond range plus one step")

endmodule

/* test/trim_button_autorepeat_checker.sv */
// Checker for the trim button block: tracks the trim state and compares every result word
`timescale 1ns / 1ps

module trim_button_autorepeat_checker
	import tba_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic                 item_stall,
	input  item_t                item,
	input  logic                 result_valid,
	input  logic                 result_stall,
	input  result_t              result,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [RANGE_W-1:0]   cfg_data,
	output int                   errors,
	output int                   pending
);

	int unsigned       range_now;
	int unsigned       step_now;
	phase_t            phase;
	logic [TIME_W-1:0] mark;
	int                trim;
	result_t           trim_words_due[$];
	int                fail_count = 0;

	function automatic beep_t tone_for(input int v);
		if (v == 0) begin
			return BEEP_CENTRE;
		end
		if (v >= int'(range_now)) begin
			return BEEP_MAX;
		end
		if (v <= -int'(range_now)) begin
			return BEEP_MIN;
		end
		return BEEP_STEP;
	endfunction

	function automatic logic elapsed(input logic [TIME_W-1:0] now,
			input logic [TIME_W-1:0] span);
		logic [TIME_W-1:0] lim;
		lim = mark + span;
		return now > lim;
	endfunction

	function automatic result_t advance_trim(input item_t w);
		beep_t   tone;
		result_t r;
		int      st;
		logic    going_down;
		logic    held;
		tone = BEEP_NONE;
		st = int'(step_now);
		case (phase)
			PH_IDLE: begin
				if (w.down_button) begin
					phase = PH_DOWN_PRESSED;
					mark = w.now_ms;
				end else if (w.up_button) begin
					phase = PH_UP_PRESSED;
					mark = w.now_ms;
				end
			end
			PH_DOWN_PRESSED: begin
				if (!w.down_button) begin
					if (trim > -int'(range_now)) begin
						trim -= st;
					end
					tone = tone_for(trim);
					phase = PH_IDLE;
				end else if (w.up_button) begin
					trim = 0;
					tone = BEEP_CENTRE;
					phase = PH_WAIT_RELEASE;
				end else if (elapsed(w.now_ms, REPEAT_START_MS)) begin
					phase = PH_DOWN_HELD;
					mark = w.now_ms;
				end
			end
			PH_UP_PRESSED: begin
				if (!w.up_button) begin
					if (trim < int'(range_now)) begin
						trim += st;
					end
					tone = tone_for(trim);
					phase = PH_IDLE;
				end else if (w.down_button) begin
					trim = 0;
					tone = BEEP_CENTRE;
					phase = PH_WAIT_RELEASE;
				end else if (elapsed(w.now_ms, REPEAT_START_MS)) begin
					phase = PH_UP_HELD;
					mark = w.now_ms;
				end
			end
			PH_DOWN_HELD, PH_UP_HELD: begin
				going_down = (phase == PH_DOWN_HELD);
				held = going_down ? w.down_button : w.up_button;
				if (!held) begin
					phase = PH_WAIT_RELEASE;
				end else if (elapsed(w.now_ms, REPEAT_EVERY_MS)) begin
					if (going_down && trim > -int'(range_now)) begin
						trim -= st;
						tone = tone_for(trim);
					end else if (!going_down && trim < int'(range_now)) begin
						trim += st;
						tone = tone_for(trim);
					end
					mark = w.now_ms;
					if (trim == 0) begin
						mark += REPEAT_PAUSE_MS;
					end
				end
			end
			PH_WAIT_RELEASE: begin
				if (!w.down_button && !w.up_button) begin
					phase = PH_IDLE;
				end
			end
			default: begin
				phase = PH_IDLE;
			end
		endcase
		r.trim_value = trim[TRIM_W-1:0];
		r.beep_kind = tone;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			range_now = int'(RANGE_RESET);
			step_now = int'(STEP_RESET);
			phase = PH_IDLE;
			mark = '0;
			trim = 0;
			trim_words_due.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_RANGE_LIM) begin
					range_now = int'(cfg_data);
				end else begin
					step_now = int'(cfg_data[STEP_W-1:0]);
				end
			end
			if (item_valid && !item_stall) begin
				trim_words_due.push_back(advance_trim(item));
			end
			if (result_valid && !result_stall) begin
				if (trim_words_due.size() == 0) begin
					if (fail_count < 10) begin
						$display("unexpected result word: trim %0d beep %0d",
							result.trim_value, result.beep_kind);
					end
					fail_count++;
				end else begin
					want = trim_words_due.pop_front();
					if (result.trim_value !== want.trim_value ||
							result.beep_kind !== want.beep_kind) begin
						if (fail_count < 10) begin
							$display("mismatch: trim exp %0d got %0d, beep exp %0d got %0d",
								want.trim_value, result.trim_value,
								want.beep_kind, result.beep_kind);
						end
						fail_count++;
					end
				end
			end
		end
		errors <= fail_count;
		pending <= trim_words_due.size();
	end

endmodule

/* test/testbench.sv */
// Top of the trim button testbench: clock, reset, button stimulus and verdict
`timescale 1ns / 1ps

module testbench;
	import tba_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int WORDS_PER_PHASE = 172;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_stall;
	item_t                item = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	result_t              result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [RANGE_W-1:0]   cfg_data = '0;
	int                   errors;
	int                   pending;

	int                   send_idle_pct = 0;
	int                   stall_pct = 0;
	int                   words_sent = 0;
	int                   cycle_count = 0;
	logic [TIME_W-1:0]    t_ms = '0;

	int unsigned range_set[8] = '{1000, 40, 0, 16383, 1000, 300, 16383, 200};
	int unsigned step_set[8]  = '{10, 10, 5, 1023, 0, 1, 1, 1023};
	int          send_set[4]  = '{0, 51, 0, 31};
	int          stall_set[4] = '{0, 0, 51, 31};

	trim_button_autorepeat dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	trim_button_autorepeat_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_word(input logic dn, input logic up, input logic [TIME_W-1:0] now);
		item_t w;
		w.down_button = dn;
		w.up_button = up;
		w.now_ms = now;
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= w;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		words_sent++;
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [RANGE_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_trim_cfg(input int unsigned rng, input int unsigned st);
		logic [RANGE_W-1:0] step_word;
		step_word = {4'($urandom_range(15)), STEP_W'(st)};
		write_reg(CFG_RANGE_LIM, RANGE_W'(rng));
		write_reg(CFG_TRIM_STEP, step_word);
	endtask

	task automatic run_gesture();
		int   kind;
		int   n;
		int   i;
		logic dn;
		logic up;
		kind = $urandom_range(99);
		dn = 1'($urandom_range(1));
		up = !dn;
		if ($urandom_range(24) == 0) begin
			t_ms = 32'hFFFF_FE00 + $urandom_range(511);
		end
		if (kind < 30) begin
			n = $urandom_range(3, 1);
			for (i = 0; i < n; i++) begin
				t_ms += $urandom_range(90);
				send_word(dn, up, t_ms);
			end
			t_ms += $urandom_range(90);
			send_word(1'b0, 1'b0, t_ms);
		end else if (kind < 60) begin
			n = $urandom_range(30, 5);
			for (i = 0; i < n; i++) begin
				t_ms += $urandom_range(70, 20);
				send_word(dn, up, t_ms);
			end
			n = $urandom_range(2, 1);
			for (i = 0; i < n; i++) begin
				t_ms += $urandom_range(40);
				send_word(1'b0, 1'b0, t_ms);
			end
		end else if (kind < 75) begin
			t_ms += $urandom_range(40);
			send_word(dn, up, t_ms);
			n = $urandom_range(2, 1);
			for (i = 0; i < n; i++) begin
				t_ms += $urandom_range(60);
				send_word(1'b1, 1'b1, t_ms);
			end
			t_ms += $urandom_range(60);
			send_word(dn, up, t_ms);
			t_ms += $urandom_range(60);
			send_word(1'b0, 1'b0, t_ms);
		end else if (kind < 85) begin
			n = $urandom_range(15, 8);
			for (i = 0; i < n; i++) begin
				t_ms += $urandom_range(60, 30);
				send_word(dn, up, t_ms);
			end
			n = $urandom_range(4, 2);
			for (i = 0; i < n; i++) begin
				t_ms += $urandom_range(60, 30);
				send_word(1'b1, 1'b1, t_ms);
			end
			t_ms += $urandom_range(60);
			send_word(1'b0, 1'b0, t_ms);
		end else begin
			n = $urandom_range(5, 1);
			for (i = 0; i < n; i++) begin
				send_word(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom());
			end
		end
	endtask

	initial begin
		int p;
		int target;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		load_trim_cfg(1000, 10);

		send_word(1'b0, 1'b0, 32'd0);
		send_word(1'b1, 1'b0, 32'd1);
		send_word(1'b0, 1'b0, 32'd2);
		send_word(1'b0, 1'b1, 32'd3);
		send_word(1'b0, 1'b0, 32'd4);
		send_word(1'b1, 1'b0, 32'd10);
		send_word(1'b1, 1'b0, 32'd260);
		send_word(1'b1, 1'b0, 32'd261);
		send_word(1'b1, 1'b0, 32'd312);
		send_word(1'b1, 1'b0, 32'd362);
		send_word(1'b1, 1'b0, 32'd363);
		send_word(1'b1, 1'b1, 32'd400);
		send_word(1'b0, 1'b1, 32'd401);
		send_word(1'b0, 1'b0, 32'd402);
		send_word(1'b0, 1'b1, 32'd403);
		send_word(1'b1, 1'b1, 32'd404);
		send_word(1'b1, 1'b0, 32'd405);
		send_word(1'b0, 1'b0, 32'd406);
		send_word(1'b1, 1'b0, 32'hFFFF_FF90);
		send_word(1'b1, 1'b0, 32'hFFFF_FFA0);
		send_word(1'b1, 1'b0, 32'hFFFF_FFFF);
		send_word(1'b0, 1'b0, 32'd0);
		send_word(1'b0, 1'b1, 32'd100);
		send_word(1'b0, 1'b1, 32'd351);
		send_word(1'b0, 1'b1, 32'd402);
		send_word(1'b0, 1'b1, 32'd953);
		send_word(1'b0, 1'b0, 32'd960);
		drain_results();

		for (p = 0; p < 8; p++) begin
			load_trim_cfg(range_set[p], step_set[p]);
			send_idle_pct = send_set[p % 4];
			stall_pct = stall_set[p % 4];
			t_ms = $urandom();
			target = words_sent + WORDS_PER_PHASE;
			while (words_sent < target) begin
				run_gesture();
			end
			drain_results();
		end

		stall_pct = 0;
		drain_results();
		if (errors == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
